[hdl/tlpi_pkg.sv]
// shared widths, codes and types for the timed linear path interpolator
// no dependencies; every other file of the block imports this package
package tlpi_pkg;

   localparam int TIME_BITS_DEF = 32;

   localparam int CMD_W      = 3;
   localparam int NOW_W      = 32;
   localparam int COORD_W    = 16;
   localparam int STEP_W     = 16;
   localparam int DUR_W      = 32;
   localparam int EV_W       = 2;
   localparam int Q16_W      = 17;
   localparam int MODE_W     = 2;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   // divider: quotient is at most one coordinate span, numerator below denominator
   localparam int NUM_W  = 32;
   localparam int QUO_W  = COORD_W;
   localparam int DIVD_W = NUM_W + QUO_W;

   localparam logic [Q16_W-1:0] Q16_ONE = Q16_W'(65536);

   // commands
   localparam logic [CMD_W-1:0] CMD_TICK    = 3'd0;
   localparam logic [CMD_W-1:0] CMD_PLAY    = 3'd1;
   localparam logic [CMD_W-1:0] CMD_STOP    = 3'd2;
   localparam logic [CMD_W-1:0] CMD_PAUSE   = 3'd3;
   localparam logic [CMD_W-1:0] CMD_RESUME  = 3'd4;
   localparam logic [CMD_W-1:0] CMD_RESTART = 3'd5;
   localparam logic [CMD_W-1:0] CMD_QUERY   = 3'd6;

   // play modes
   localparam logic [MODE_W-1:0] MODE_STOPPED = 2'd0;
   localparam logic [MODE_W-1:0] MODE_PLAYING = 2'd1;
   localparam logic [MODE_W-1:0] MODE_PAUSED  = 2'd2;

   // events
   localparam logic [EV_W-1:0] EV_NONE = 2'd0;
   localparam logic [EV_W-1:0] EV_STEP = 2'd1;
   localparam logic [EV_W-1:0] EV_END  = 2'd2;
   localparam logic [EV_W-1:0] EV_STOP = 2'd3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_START_X     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_START_Y     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_END_X       = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_END_Y       = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_TOTAL_STEPS = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_STEP_PERIOD = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_DURATION    = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_TIME_MODE   = 3'd7;

   typedef struct packed {
      logic [COORD_W-1:0] start_x;
      logic [COORD_W-1:0] start_y;
      logic [COORD_W-1:0] end_x;
      logic [COORD_W-1:0] end_y;
      logic [STEP_W-1:0]  total_steps;
      logic [STEP_W-1:0]  step_period_ms;
      logic [DUR_W-1:0]   duration_ms;
      logic               use_time_mode;
   } cfg_type;

   typedef struct packed {
      logic              start;
      logic [DIVD_W-1:0] dividend;
      logic [NUM_W-1:0]  divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [QUO_W-1:0] quotient;
      logic             rem_nz;
   } div_rsp_type;

endpackage

[hdl/tlpi_if.sv]
// request and response channel interfaces of the path interpolator
// depends on tlpi_pkg for field widths
interface tlpi_req_if import tlpi_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [CMD_W-1:0] command;
   logic [NOW_W-1:0] now_ms;

   modport source (output valid, command, now_ms, input ready);
   modport sink (input valid, command, now_ms, output ready);
endinterface

interface tlpi_rsp_if import tlpi_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [COORD_W-1:0] pos_x;
   logic signed [COORD_W-1:0] pos_y;
   logic [EV_W-1:0]           event_code;
   logic                      is_playing;
   logic                      is_paused;
   logic [Q16_W-1:0]          progress_q16;

   modport source (output valid, pos_x, pos_y, event_code, is_playing, is_paused,
                   progress_q16, input ready);
   modport sink (input valid, pos_x, pos_y, event_code, is_playing, is_paused,
                 progress_q16, output ready);
endinterface

[hdl/timed_linear_path_interpolator_top.sv]
// top level of the timed linear path interpolator: registers, core, divider
// depends on tlpi_pkg, tlpi_if, tlpi_div and tlpi_core
//
//   port      dir    role
//   req_ch    sink   command and now_ms per item, valid/ready
//   rsp_ch    source position, event, play flags and q16 progress per item
//   csr_*     in     register writes, index 0..7, no read-back
//
// every item gives exactly one result item; a new item is taken only when
// the sequencer is idle, but a finished result may still wait in the output
// register while the next item is taken
// a due tick that steps runs three passes of the shared divider
// (x, y and progress), each of the first two after a multiply step;
// other items that leave the path playing need one divider pass, for progress,
// unless progress is complete; anything else, a tick that ends the path included, needs none
// reset is synchronous and active high and clears registers and path state
module timed_linear_path_interpolator_top import tlpi_pkg::*; #(
   parameter int TIME_BITS = TIME_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   tlpi_req_if.sink              req_ch,
   tlpi_rsp_if.source            rsp_ch
);

   cfg_type     cfg_ff, cfg_in;
   div_req_type div_req;
   div_rsp_type div_rsp;

   // register write decode, each register keeps its own width
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            REG_START_X:     cfg_in.start_x        = csr_wdata[COORD_W-1:0];
            REG_START_Y:     cfg_in.start_y        = csr_wdata[COORD_W-1:0];
            REG_END_X:       cfg_in.end_x          = csr_wdata[COORD_W-1:0];
            REG_END_Y:       cfg_in.end_y          = csr_wdata[COORD_W-1:0];
            REG_TOTAL_STEPS: cfg_in.total_steps    = csr_wdata[STEP_W-1:0];
            REG_STEP_PERIOD: cfg_in.step_period_ms = csr_wdata[STEP_W-1:0];
            REG_DURATION:    cfg_in.duration_ms    = csr_wdata[DUR_W-1:0];
            REG_TIME_MODE:   cfg_in.use_time_mode  = csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // play state, step scheduling and the multiply/divide sequence
   tlpi_core #(
      .TIME_BITS (TIME_BITS)
   ) u_core (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg_ff),
      .req     (req_ch),
      .rsp     (rsp_ch),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // one divider shared by both axes and the progress fraction
   tlpi_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

endmodule

[hdl/tlpi_div.sv]
// shared restoring divider, one quotient bit per cycle
// depends on tlpi_pkg; the upper dividend part must be below the divisor
module tlpi_div import tlpi_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   localparam int CNT_W = $clog2(QUO_W);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(QUO_W - 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [NUM_W-1:0] rem_ff, rem_in;
   logic [QUO_W-1:0] quo_ff, quo_in;
   logic [NUM_W-1:0] den_ff, den_in;

   logic [NUM_W:0] trial;
   logic [NUM_W:0] diff;
   logic           ge;

   always_comb begin
      trial = {rem_ff, quo_ff[QUO_W-1]};
      diff  = trial - {1'b0, den_ff};
      ge    = trial >= {1'b0, den_ff};

      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;

      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = div_req.dividend[DIVD_W-1:QUO_W];
         quo_in  = div_req.dividend[QUO_W-1:0];
         den_in  = div_req.divisor;
      end else if (busy_ff) begin
         rem_in = ge ? diff[NUM_W-1:0] : trial[NUM_W-1:0];
         quo_in = {quo_ff[QUO_W-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;
   assign div_rsp.rem_nz   = rem_ff != '0;

endmodule

[hdl/tlpi_core.sv]
// play state machine, path state and step sequencer of the interpolator
// depends on tlpi_pkg and tlpi_if; reaches the shared divider tlpi_div through its ports
module tlpi_core import tlpi_pkg::*; #(
   parameter int TIME_BITS = TIME_BITS_DEF
) (
   input  logic           clock,
   input  logic           reset,
   input  cfg_type        cfg,
   tlpi_req_if.sink       req,
   tlpi_rsp_if.source     rsp,
   output div_req_type    div_req,
   input  div_rsp_type    div_rsp
);

   localparam int CW = (TIME_BITS > DUR_W) ? TIME_BITS : DUR_W;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_CMD   = 3'd1;
   localparam logic [2:0] S_PROG  = 3'd2;
   localparam logic [2:0] S_MUL   = 3'd3;
   localparam logic [2:0] S_DIVGO = 3'd4;
   localparam logic [2:0] S_DIVW  = 3'd5;
   localparam logic [2:0] S_DONE  = 3'd6;

   localparam logic [1:0] PH_X = 2'd0;
   localparam logic [1:0] PH_Y = 2'd1;
   localparam logic [1:0] PH_P = 2'd2;

   logic [2:0]           state_ff, state_in;
   logic [1:0]           phase_ff, phase_in;
   logic [CMD_W-1:0]     cmd_ff, cmd_in;
   logic [TIME_BITS-1:0] now_ff, now_in;
   logic [MODE_W-1:0]    mode_ff, mode_in;
   logic [COORD_W-1:0]   cur_x_ff, cur_x_in;
   logic [COORD_W-1:0]   cur_y_ff, cur_y_in;
   logic [STEP_W-1:0]    step_ff, step_in;
   logic [TIME_BITS-1:0] began_ff, began_in;
   logic [TIME_BITS-1:0] paused_ff, paused_in;
   logic [TIME_BITS-1:0] next_ff, next_in;
   logic                 tick_ff, tick_in;
   logic [EV_W-1:0]      ev_ff, ev_in;
   logic [NUM_W-1:0]     num_ff, num_in;
   logic [NUM_W-1:0]     den_ff, den_in;
   logic [DIVD_W-1:0]    prod_ff, prod_in;
   logic [Q16_W-1:0]     pq_ff, pq_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [COORD_W-1:0]   out_x_ff, out_x_in;
   logic [COORD_W-1:0]   out_y_ff, out_y_in;
   logic [EV_W-1:0]      out_ev_ff, out_ev_in;
   logic                 out_play_ff, out_play_in;
   logic                 out_pause_ff, out_pause_in;
   logic [Q16_W-1:0]     out_pq_ff, out_pq_in;

   // schedule: next step one period on, but never in the past
   logic [TIME_BITS-1:0] sched_sum;
   logic [TIME_BITS-1:0] sched_val;

   // progress as num over den, ok false when progress is one
   logic [TIME_BITS-1:0] elapsed;
   logic                 time_ok;
   logic                 step_ok;
   logic                 prog_ok;
   logic [NUM_W-1:0]     prog_num;
   logic [NUM_W-1:0]     prog_den;

   // lerp of the current axis
   logic [COORD_W-1:0]   ax_s;
   logic [COORD_W-1:0]   ax_e;
   logic [COORD_W:0]     ax_d;
   logic [COORD_W:0]     ax_abs;
   logic                 ax_neg;
   logic [COORD_W+1:0]   ax_s_ext;
   logic [COORD_W+1:0]   ax_q_ext;
   logic [COORD_W+1:0]   ax_base;
   logic [COORD_W+1:0]   ax_res;
   logic                 ax_base_neg;
   logic                 ax_base_pos;

   always_comb begin
      sched_sum = next_ff + TIME_BITS'(cfg.step_period_ms);
      sched_val = (sched_sum < now_ff) ? now_ff : sched_sum;

      elapsed  = now_ff - began_ff;
      time_ok  = (now_ff > began_ff) && (cfg.duration_ms != '0) &&
                 (CW'(elapsed) < CW'(cfg.duration_ms));
      step_ok  = (cfg.total_steps != '0) && (step_ff < cfg.total_steps);
      prog_ok  = cfg.use_time_mode ? time_ok : step_ok;
      prog_num = cfg.use_time_mode ? NUM_W'(elapsed) : NUM_W'(step_ff);
      prog_den = cfg.use_time_mode ? NUM_W'(cfg.duration_ms) : NUM_W'(cfg.total_steps);

      ax_s   = (phase_ff == PH_X) ? cfg.start_x : cfg.start_y;
      ax_e   = (phase_ff == PH_X) ? cfg.end_x : cfg.end_y;
      ax_d   = {ax_e[COORD_W-1], ax_e} - {ax_s[COORD_W-1], ax_s};
      ax_neg = ax_d[COORD_W];
      ax_abs = ax_neg ? (~ax_d + 1'b1) : ax_d;

      ax_s_ext    = {{2{ax_s[COORD_W-1]}}, ax_s};
      ax_q_ext    = {2'b00, div_rsp.quotient};
      ax_base     = ax_neg ? (ax_s_ext - ax_q_ext) : (ax_s_ext + ax_q_ext);
      ax_base_neg = ax_base[COORD_W+1];
      ax_base_pos = !ax_base[COORD_W+1] && (ax_base != '0);
      // truncate toward zero where the exact value has a fraction
      ax_res = ax_base;
      if (div_rsp.rem_nz) begin
         if (!ax_neg && ax_base_neg) begin
            ax_res = ax_base + 1'b1;
         end else if (ax_neg && ax_base_pos) begin
            ax_res = ax_base - 1'b1;
         end
      end
   end

   always_comb begin
      state_in  = state_ff;
      phase_in  = phase_ff;
      cmd_in    = cmd_ff;
      now_in    = now_ff;
      mode_in   = mode_ff;
      cur_x_in  = cur_x_ff;
      cur_y_in  = cur_y_ff;
      step_in   = step_ff;
      began_in  = began_ff;
      paused_in = paused_ff;
      next_in   = next_ff;
      tick_in   = tick_ff;
      ev_in     = ev_ff;
      num_in    = num_ff;
      den_in    = den_ff;
      prod_in   = prod_ff;
      pq_in     = pq_ff;

      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      out_x_in     = out_x_ff;
      out_y_in     = out_y_ff;
      out_ev_in    = out_ev_ff;
      out_play_in  = out_play_ff;
      out_pause_in = out_pause_ff;
      out_pq_in    = out_pq_ff;

      div_req.start    = 1'b0;
      div_req.dividend = (phase_ff == PH_P) ? {num_ff, {QUO_W{1'b0}}} : prod_ff;
      div_req.divisor  = den_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req.valid) begin
               cmd_in   = req.command;
               now_in   = TIME_BITS'(req.now_ms);
               state_in = S_CMD;
            end
         end
         S_CMD: begin
            ev_in    = EV_NONE;
            tick_in  = 1'b0;
            state_in = S_PROG;
            unique case (cmd_ff) inside
               CMD_TICK: begin
                  if (mode_ff == MODE_PLAYING && now_ff >= next_ff) begin
                     step_in = step_ff + 1'b1;
                     tick_in = 1'b1;
                  end
               end
               CMD_PLAY: begin
                  cur_x_in = cfg.start_x;
                  cur_y_in = cfg.start_y;
                  began_in = now_ff;
                  mode_in  = MODE_PLAYING;
                  next_in  = sched_val;
                  step_in  = '0;
               end
               CMD_STOP: begin
                  if (mode_ff != MODE_STOPPED) begin
                     mode_in = MODE_STOPPED;
                     ev_in   = EV_STOP;
                  end
               end
               CMD_PAUSE: begin
                  if (mode_ff == MODE_PLAYING) begin
                     mode_in   = MODE_PAUSED;
                     paused_in = now_ff;
                  end
               end
               CMD_RESUME, CMD_RESTART: begin
                  if (mode_ff == MODE_PAUSED) begin
                     began_in = began_ff + (now_ff - paused_ff);
                     mode_in  = MODE_PLAYING;
                     next_in  = sched_val;
                  end else if (mode_ff != MODE_PLAYING && cmd_ff == CMD_RESTART) begin
                     cur_x_in = cfg.start_x;
                     cur_y_in = cfg.start_y;
                     began_in = now_ff;
                     mode_in  = MODE_PLAYING;
                     next_in  = sched_val;
                     step_in  = '0;
                  end
               end
               default: begin
               end
            endcase
         end
         S_PROG: begin
            num_in = prog_num;
            den_in = prog_den;
            pq_in  = Q16_ONE;
            if (tick_ff) begin
               if (prog_ok) begin
                  ev_in    = EV_STEP;
                  next_in  = sched_val;
                  phase_in = PH_X;
                  state_in = S_MUL;
               end else begin
                  mode_in  = MODE_STOPPED;
                  next_in  = '0;
                  step_in  = '0;
                  ev_in    = EV_END;
                  state_in = S_DONE;
               end
            end else if (mode_ff == MODE_PLAYING && prog_ok) begin
               phase_in = PH_P;
               state_in = S_DIVGO;
            end else begin
               state_in = S_DONE;
            end
         end
         S_MUL: begin
            prod_in  = DIVD_W'(ax_abs[COORD_W-1:0]) * DIVD_W'(num_ff);
            state_in = S_DIVGO;
         end
         S_DIVGO: begin
            div_req.start = 1'b1;
            state_in      = S_DIVW;
         end
         S_DIVW: begin
            if (div_rsp.done) begin
               unique case (phase_ff)
                  PH_X: begin
                     cur_x_in = ax_res[COORD_W-1:0];
                     phase_in = PH_Y;
                     state_in = S_MUL;
                  end
                  PH_Y: begin
                     cur_y_in = ax_res[COORD_W-1:0];
                     phase_in = PH_P;
                     state_in = S_DIVGO;
                  end
                  default: begin
                     pq_in    = {1'b0, div_rsp.quotient};
                     state_in = S_DONE;
                  end
               endcase
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in = 1'b1;
               out_x_in     = cur_x_ff;
               out_y_in     = cur_y_ff;
               out_ev_in    = ev_ff;
               out_play_in  = mode_ff != MODE_STOPPED;
               out_pause_in = mode_ff == MODE_PAUSED;
               out_pq_in    = pq_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         phase_ff     <= PH_X;
         mode_ff      <= MODE_STOPPED;
         cur_x_ff     <= '0;
         cur_y_ff     <= '0;
         step_ff      <= '0;
         began_ff     <= '0;
         paused_ff    <= '0;
         next_ff      <= '0;
         tick_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         mode_ff      <= mode_in;
         cur_x_ff     <= cur_x_in;
         cur_y_ff     <= cur_y_in;
         step_ff      <= step_in;
         began_ff     <= began_in;
         paused_ff    <= paused_in;
         next_ff      <= next_in;
         tick_ff      <= tick_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff       <= cmd_in;
      now_ff       <= now_in;
      ev_ff        <= ev_in;
      num_ff       <= num_in;
      den_ff       <= den_in;
      prod_ff      <= prod_in;
      pq_ff        <= pq_in;
      out_x_ff     <= out_x_in;
      out_y_ff     <= out_y_in;
      out_ev_ff    <= out_ev_in;
      out_play_ff  <= out_play_in;
      out_pause_ff <= out_pause_in;
      out_pq_ff    <= out_pq_in;
   end

   assign req.ready        = state_ff == S_IDLE;
   assign rsp.valid        = rsp_valid_ff;
   assign rsp.pos_x        = $signed(out_x_ff);
   assign rsp.pos_y        = $signed(out_y_ff);
   assign rsp.event_code   = out_ev_ff;
   assign rsp.is_playing   = out_play_ff;
   assign rsp.is_paused    = out_pause_ff;
   assign rsp.progress_q16 = out_pq_ff;

endmodule

[sim/timed_linear_path_interpolator_top_tb.sv]
`timescale 1ns / 100ps
// self-checking testbench for the timed linear path interpolator top level
// depends on tlpi_pkg, tlpi_if and timed_linear_path_interpolator_top
module timed_linear_path_interpolator_top_tb;
   import tlpi_pkg::*;

   // command 7 has no name in the package; the block treats it as a query
   localparam logic [CMD_W-1:0] CMD_SPARE = 3'd7;

   localparam int CYCLE_LIMIT   = 600000;
   localparam int PLAN_ROWS     = 36;
   localparam int PHASES        = 8;
   localparam int ITEMS_A_PHASE = 88;
   localparam int HOLD_CYCLES   = 400;
   localparam int DRAIN_CYCLES  = 100;

   // one result item, field for field as on rsp_ch
   typedef struct packed {
      logic [COORD_W-1:0] pos_x;
      logic [COORD_W-1:0] pos_y;
      logic [EV_W-1:0]    event_code;
      logic               is_playing;
      logic               is_paused;
      logic [Q16_W-1:0]   progress_q16;
   } path_result_type;

   typedef enum bit {ROW_ITEM, ROW_REG} row_kind_type;

   // directed row: an item (code is a command) or a register write (code is an index)
   typedef struct {
      row_kind_type       kind;
      logic [CMD_W-1:0]   code;
      logic [NOW_W-1:0]   value;
      bit                 typed;
      path_result_type    want;
   } plan_row_type;

   // results that can be read straight off the behavior
   localparam path_result_type NO_WANT = '0;
   localparam path_result_type AT_REST =
      '{16'h0000, 16'h0000, EV_NONE, 1'b0, 1'b0, Q16_ONE};
   localparam path_result_type AT_CORNER =
      '{16'h8000, 16'h7FFF, EV_NONE, 1'b1, 1'b0, 17'd0};
   localparam path_result_type ENDED_AT_CORNER =
      '{16'h8000, 16'h7FFF, EV_END, 1'b0, 1'b0, Q16_ONE};

   logic                  clock;
   logic                  reset;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   tlpi_req_if req_ch ();
   tlpi_rsp_if rsp_ch ();

   timed_linear_path_interpolator_top uut (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch)
   );

   // predictor state: register copy plus path state, at reset values
   cfg_type             path_cfg   = '0;
   logic [MODE_W-1:0]   path_mode  = MODE_STOPPED;
   logic [COORD_W-1:0]  path_x     = '0;
   logic [COORD_W-1:0]  path_y     = '0;
   logic [STEP_W-1:0]   steps_done = '0;
   logic [NOW_W-1:0]    t_begin    = '0;
   logic [NOW_W-1:0]    t_paused   = '0;
   logic [NOW_W-1:0]    t_next     = '0;

   path_result_type path_results_due[$];
   int              mismatch_count = 0;
   int              send_idle_pct  = 0;
   int              stall_pct      = 0;
   int              hold_left      = 0;
   int              cycle_count    = 0;

   // directed part: idle behavior, a corner-to-corner path in step mode with pause
   // and resume, time wrap, zero steps, time mode at start and zero duration
   plan_row_type plan [PLAN_ROWS] = '{
      '{ROW_ITEM, CMD_QUERY,       32'd0,          1'b1, AT_REST},
      '{ROW_ITEM, CMD_TICK,        32'd0,          1'b1, AT_REST},
      '{ROW_ITEM, CMD_STOP,        32'd0,          1'b1, AT_REST},
      '{ROW_ITEM, CMD_SPARE,       32'hFFFF_FFFF,  1'b1, AT_REST},
      '{ROW_REG,  REG_START_X,     32'h0000_8000,  1'b0, NO_WANT},
      '{ROW_REG,  REG_START_Y,     32'h0000_7FFF,  1'b0, NO_WANT},
      '{ROW_REG,  REG_END_X,       32'h0000_7FFF,  1'b0, NO_WANT},
      '{ROW_REG,  REG_END_Y,       32'h0000_8000,  1'b0, NO_WANT},
      '{ROW_REG,  REG_TOTAL_STEPS, 32'd4,          1'b0, NO_WANT},
      '{ROW_REG,  REG_STEP_PERIOD, 32'd10,         1'b0, NO_WANT},
      '{ROW_ITEM, CMD_PLAY,        32'd100,        1'b1, AT_CORNER},
      '{ROW_ITEM, CMD_TICK,        32'd100,        1'b0, NO_WANT},
      '{ROW_ITEM, CMD_PAUSE,       32'd107,        1'b0, NO_WANT},
      '{ROW_ITEM, CMD_TICK,        32'd200,        1'b0, NO_WANT},
      '{ROW_ITEM, CMD_RESUME,      32'd250,        1'b0, NO_WANT},
      '{ROW_ITEM, CMD_TICK,        32'd250,        1'b0, NO_WANT},
      '{ROW_ITEM, CMD_RESUME,      32'd260,        1'b0, NO_WANT},
      '{ROW_ITEM, CMD_TICK,        32'hFFFF_FFF0,  1'b0, NO_WANT},
      '{ROW_ITEM, CMD_TICK,        32'hFFFF_FFFF,  1'b0, NO_WANT},
      '{ROW_ITEM, CMD_RESTART,     32'd300,        1'b0, NO_WANT},
      '{ROW_ITEM, CMD_PAUSE,       32'd310,        1'b0, NO_WANT},
      '{ROW_ITEM, CMD_STOP,        32'd320,        1'b0, NO_WANT},
      '{ROW_ITEM, CMD_PLAY,        32'd400,        1'b0, NO_WANT},
      '{ROW_ITEM, CMD_PLAY,        32'd401,        1'b0, NO_WANT},
      '{ROW_REG,  REG_TOTAL_STEPS, 32'd0,          1'b0, NO_WANT},
      '{ROW_ITEM, CMD_TICK,        32'hFFFF_FFFF,  1'b1, ENDED_AT_CORNER},
      '{ROW_REG,  REG_TIME_MODE,   32'd1,          1'b0, NO_WANT},
      '{ROW_REG,  REG_DURATION,    32'd1000,       1'b0, NO_WANT},
      '{ROW_REG,  REG_STEP_PERIOD, 32'd0,          1'b0, NO_WANT},
      '{ROW_ITEM, CMD_PLAY,        32'd5000,       1'b0, NO_WANT},
      '{ROW_ITEM, CMD_TICK,        32'd5000,       1'b1, ENDED_AT_CORNER},
      '{ROW_ITEM, CMD_RESTART,     32'd6000,       1'b0, NO_WANT},
      '{ROW_ITEM, CMD_TICK,        32'd6250,       1'b0, NO_WANT},
      '{ROW_ITEM, CMD_QUERY,       32'd6500,       1'b0, NO_WANT},
      '{ROW_REG,  REG_DURATION,    32'd0,          1'b0, NO_WANT},
      '{ROW_ITEM, CMD_TICK,        32'd7000,       1'b0, NO_WANT}
   };

   // ---------------------------------------------------------------- predictor

   // progress as num/den; 0 means the path is complete (p is one)
   function automatic bit path_fraction(input logic [NOW_W-1:0] now,
                                        output logic [NUM_W-1:0] num,
                                        output logic [NUM_W-1:0] den);
      bit ok;
      ok  = 1'b0;
      num = '0;
      den = 32'd1;
      if (path_cfg.use_time_mode) begin
         // at or before the start, or with no duration, the path counts as done
         if (now > t_begin && path_cfg.duration_ms != 0 &&
             now - t_begin < path_cfg.duration_ms) begin
            num = now - t_begin;
            den = path_cfg.duration_ms;
            ok  = 1'b1;
         end
      end else if (path_cfg.total_steps != 0 && steps_done < path_cfg.total_steps) begin
         num = 32'(steps_done);
         den = 32'(path_cfg.total_steps);
         ok  = 1'b1;
      end
      return ok;
   endfunction

   // start + (end - start) * num / den, exact, truncated toward zero
   function automatic logic [COORD_W-1:0] coord_at(input logic signed [COORD_W-1:0] s,
                                                  input logic signed [COORD_W-1:0] e,
                                                  input logic [NUM_W-1:0] num,
                                                  input logic [NUM_W-1:0] den);
      longint          span, q, b;
      longint unsigned mag, prod, r;
      span = longint'(e) - longint'(s);
      mag  = (span < 0) ? -span : span;
      prod = mag * num;
      q    = prod / den;
      r    = prod % den;
      if (span >= 0) begin
         b = s + q;
         if (b < 0 && r > 0) b = b + 1;
      end else begin
         b = s - q;
         if (b > 0 && r > 0) b = b - 1;
      end
      return 16'(b);
   endfunction

   // next step one period on, but never in the past
   function automatic void schedule_next(input logic [NOW_W-1:0] now);
      t_next = t_next + 32'(path_cfg.step_period_ms);
      if (t_next < now) t_next = now;
   endfunction

   function automatic void begin_path(input logic [NOW_W-1:0] now);
      path_x    = path_cfg.start_x;
      path_y    = path_cfg.start_y;
      t_begin   = now;
      path_mode = MODE_PLAYING;
      schedule_next(now);
      steps_done = '0;
   endfunction

   // applies one item to the path state and returns the result it causes
   function automatic path_result_type predict_path_step(input logic [CMD_W-1:0] cmd,
                                                         input logic [NOW_W-1:0] now);
      path_result_type  res;
      logic [NUM_W-1:0] num, den;
      logic [EV_W-1:0]  ev;
      ev = EV_NONE;
      case (cmd)
         CMD_TICK: begin
            // only a due tick while playing moves the point, one step at most
            if (path_mode == MODE_PLAYING && now >= t_next) begin
               steps_done = steps_done + 16'd1;
               if (path_fraction(now, num, den)) begin
                  path_x = coord_at(path_cfg.start_x, path_cfg.end_x, num, den);
                  path_y = coord_at(path_cfg.start_y, path_cfg.end_y, num, den);
                  ev = EV_STEP;
                  schedule_next(now);
               end else begin
                  // path end: point stays, schedule and count clear
                  path_mode  = MODE_STOPPED;
                  t_next     = '0;
                  steps_done = '0;
                  ev = EV_END;
               end
            end
         end
         CMD_PLAY: begin_path(now);
         CMD_STOP: begin
            if (path_mode != MODE_STOPPED) begin
               path_mode = MODE_STOPPED;
               ev = EV_STOP;
            end
         end
         CMD_PAUSE: begin
            if (path_mode == MODE_PLAYING) begin
               path_mode = MODE_PAUSED;
               t_paused  = now;
            end
         end
         CMD_RESUME, CMD_RESTART: begin
            if (path_mode == MODE_PAUSED) begin
               // the pause shifts the start by its length
               t_begin   = t_begin + (now - t_paused);
               path_mode = MODE_PLAYING;
               schedule_next(now);
            end else if (path_mode != MODE_PLAYING && cmd == CMD_RESTART) begin
               begin_path(now);
            end
         end
         default: ;
      endcase
      res.progress_q16 = Q16_ONE;
      if (path_mode == MODE_PLAYING && path_fraction(now, num, den))
         res.progress_q16 = 17'((64'(num) << 16) / 64'(den));
      res.pos_x      = path_x;
      res.pos_y      = path_y;
      res.event_code = ev;
      res.is_playing = (path_mode != MODE_STOPPED);
      res.is_paused  = (path_mode == MODE_PAUSED);
      return res;
   endfunction

   // ---------------------------------------------------------------- drivers

   // offer one item, wait for it to be taken, then record what it must produce
   task automatic offer_item(input logic [CMD_W-1:0] cmd, input logic [NOW_W-1:0] now,
                             input bit typed, input path_result_type want);
      path_result_type due;
      csr_wr_en <= 1'b0;
      if ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 70)) @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.command <= cmd;
      req_ch.now_ms  <= now;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      due = predict_path_step(cmd, now);
      path_results_due.push_back(typed ? want : due);
   endtask

   // stop offering and wait until every result has come back
   task automatic drain_path();
      req_ch.valid <= 1'b0;
      while (path_results_due.size() != 0) @(posedge clock);
   endtask

   // one register write; enable stays high until the next item lowers it
   task automatic put_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      case (idx)
         REG_START_X:     path_cfg.start_x        = data[COORD_W-1:0];
         REG_START_Y:     path_cfg.start_y        = data[COORD_W-1:0];
         REG_END_X:       path_cfg.end_x          = data[COORD_W-1:0];
         REG_END_Y:       path_cfg.end_y          = data[COORD_W-1:0];
         REG_TOTAL_STEPS: path_cfg.total_steps    = data[STEP_W-1:0];
         REG_STEP_PERIOD: path_cfg.step_period_ms = data[STEP_W-1:0];
         REG_DURATION:    path_cfg.duration_ms    = data[DUR_W-1:0];
         REG_TIME_MODE:   path_cfg.use_time_mode  = data[0];
         default: ;
      endcase
   endtask

   // coordinates lean on the extremes of the signed range
   function automatic logic [COORD_W-1:0] pick_coord();
      logic [COORD_W-1:0] c;
      case ($urandom_range(3))
         0:       c = 16'h8000;
         1:       c = 16'h7FFF;
         default: c = 16'($urandom);
      endcase
      return c;
   endfunction

   // ---------------------------------------------------------------- clock and watchdog

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timed_linear_path_interpolator_top_tb: done, errors");
      $finish;
   end

   // long receiver hold-off requested by the stimulus, counted down per cycle
   initial begin
      forever begin
         @(posedge clock);
         if (hold_left > 0) hold_left--;
      end
   end

   // ---------------------------------------------------------------- result side

   // checks each taken result against the oldest one due, then picks next ready;
   // ready stays low while a hold-off is running
   initial begin
      path_result_type want;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            if (path_results_due.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("unexpected result item: x=%0d y=%0d ev=%0d play=%0b pause=%0b q16=%0d",
                           $signed(rsp_ch.pos_x), $signed(rsp_ch.pos_y), rsp_ch.event_code,
                           rsp_ch.is_playing, rsp_ch.is_paused, rsp_ch.progress_q16);
            end else begin
               want = path_results_due.pop_front();
               if (rsp_ch.pos_x !== want.pos_x || rsp_ch.pos_y !== want.pos_y ||
                   rsp_ch.event_code !== want.event_code ||
                   rsp_ch.is_playing !== want.is_playing ||
                   rsp_ch.is_paused !== want.is_paused ||
                   rsp_ch.progress_q16 !== want.progress_q16) begin
                  mismatch_count++;
                  if (mismatch_count <= 10) begin
                     $display("result mismatch at %0t", $realtime);
                     $display("  want x=%0d y=%0d ev=%0d play=%0b pause=%0b q16=%0d",
                              $signed(want.pos_x), $signed(want.pos_y), want.event_code,
                              want.is_playing, want.is_paused, want.progress_q16);
                     $display("  got  x=%0d y=%0d ev=%0d play=%0b pause=%0b q16=%0d",
                              $signed(rsp_ch.pos_x), $signed(rsp_ch.pos_y),
                              rsp_ch.event_code, rsp_ch.is_playing, rsp_ch.is_paused,
                              rsp_ch.progress_q16);
                  end
               end
            end
         end
         if (hold_left > 0) begin
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   // ---------------------------------------------------------------- stimulus

   initial begin
      logic [CSR_DATA_W-1:0] reg_val [8];
      logic [STEP_W-1:0]     steps, period;
      logic [DUR_W-1:0]      dur;
      logic [NOW_W-1:0]      clk_ms, now;
      logic [CMD_W-1:0]      cmd;
      bit                    time_mode;
      int unsigned           span;
      int                    r;

      reset          <= 1'b1;
      csr_wr_en      <= 1'b0;
      csr_index      <= '0;
      csr_wdata      <= '0;
      req_ch.valid   <= 1'b0;
      req_ch.command <= CMD_QUERY;
      req_ch.now_ms  <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed table, registers written only with nothing in flight
      foreach (plan[i]) begin
         if (plan[i].kind == ROW_REG) begin
            drain_path();
            put_reg(plan[i].code, plan[i].value);
         end else begin
            offer_item(plan[i].code, plan[i].value, plan[i].typed, plan[i].want);
         end
      end

      // random phases: new settings each time, idling pattern cycles through four
      for (int phase = 0; phase < PHASES; phase++) begin
         drain_path();

         // short paths mostly, so that most phases see many ends and restarts
         if (phase == 6) begin
            steps  = 16'd1;
            period = 16'd0;
            dur    = 32'd1;
         end else if (phase == 7) begin
            steps  = 16'hFFFF;
            period = 16'hFFFF;
            dur    = 32'hFFFF_FFFF;
         end else begin
            case ($urandom_range(9))
               0:       steps = 16'd0;
               1:       steps = 16'hFFFF;
               default: steps = 16'($urandom_range(1, 12));
            endcase
            case ($urandom_range(9))
               0:       period = 16'd0;
               1:       period = 16'hFFFF;
               default: period = 16'($urandom_range(1, 20));
            endcase
            case ($urandom_range(9))
               0:       dur = 32'd0;
               1:       dur = 32'hFFFF_FFFF;
               2:       dur = $urandom;
               default: dur = $urandom_range(1, 400);
            endcase
         end
         time_mode = (phase == 0) ? 1'b0 : (phase == 1) ? 1'b1 : 1'($urandom_range(1));

         // junk in the unused upper bits must be ignored
         reg_val[REG_START_X]     = {16'($urandom), pick_coord()};
         reg_val[REG_START_Y]     = {16'($urandom), pick_coord()};
         reg_val[REG_END_X]       = {16'($urandom), pick_coord()};
         reg_val[REG_END_Y]       = {16'($urandom), pick_coord()};
         reg_val[REG_TOTAL_STEPS] = {16'($urandom), steps};
         reg_val[REG_STEP_PERIOD] = {16'($urandom), period};
         reg_val[REG_DURATION]    = dur;
         reg_val[REG_TIME_MODE]   = {31'($urandom), time_mode};
         foreach (reg_val[k]) put_reg(CSR_IDX_W'(k), reg_val[k]);

         case (phase % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 56; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 56; end
            default: begin send_idle_pct = 38; stall_pct = 38; end
         endcase
         // long receiver hold-off while items keep coming, fills the block up
         if (phase == 4) hold_left = HOLD_CYCLES;

         // time base: anywhere, just below the wrap, or low
         case ($urandom_range(2))
            0:       clk_ms = $urandom;
            1:       clk_ms = 32'hFFFF_FFFF - $urandom_range(0, 2000);
            default: clk_ms = $urandom_range(0, 50000);
         endcase
         // time advance per item sized so that steps come due often
         if (time_mode)
            span = ((dur / 6 > 100000) ? 100000 : dur / 6) + 3;
         else
            span = 2 * 32'(period) + 3;

         for (int n = 0; n < ITEMS_A_PHASE; n++) begin
            r = $urandom_range(99);
            if (r < 64)      cmd = CMD_TICK;
            else if (r < 68) cmd = CMD_PLAY;
            else if (r < 74) cmd = CMD_PAUSE;
            else if (r < 81) cmd = CMD_RESUME;
            else if (r < 87) cmd = CMD_RESTART;
            else if (r < 91) cmd = CMD_STOP;
            else if (r < 96) cmd = CMD_QUERY;
            else             cmd = CMD_SPARE;
            clk_ms = clk_ms + $urandom_range(0, span);
            // a few items carry a stray time, possibly going backward
            now = ($urandom_range(99) < 3) ? $urandom : clk_ms;
            offer_item(cmd, now, 1'b0, NO_WANT);
         end
      end

      drain_path();
      // catch any stray result after the last one due
      repeat (DRAIN_CYCLES) @(posedge clock);
      mismatch_count += path_results_due.size();
      if (mismatch_count == 0)
         $display("timed_linear_path_interpolator_top_tb: done, clean");
      else
         $display("timed_linear_path_interpolator_top_tb: done, errors");
      $finish;
   end

endmodule

[timed_linear_path_interpolator_top.f]
hdl/tlpi_pkg.sv
hdl/tlpi_if.sv
hdl/tlpi_div.sv
hdl/tlpi_core.sv
hdl/timed_linear_path_interpolator_top.sv
sim/timed_linear_path_interpolator_top_tb.sv
